### hw/rtl/psq_pkg.sv
// Package for the polyline stroke quad expander.
// Holds the request/response word types, mode and register codes and limits.
// No dependencies.
package psq_pkg;

   localparam int unsigned MAX_SEGMENTS = 512;
   localparam logic [15:0] BASE_LIMIT = 16'(4 * MAX_SEGMENTS);
   localparam logic [15:0] WIDTH_MIN = 16'd256;

   localparam logic [1:0] MODE_BEGIN = 2'd0;
   localparam logic [1:0] MODE_MOVE  = 2'd1;
   localparam logic [1:0] MODE_LINE  = 2'd2;

   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_TRI    = 1'b1;

   localparam logic CSR_LINE_WIDTH  = 1'b0;
   localparam logic CSR_STROKE_RGBA = 1'b1;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
   } req_word_type;

   typedef struct packed {
      logic               kind;
      logic signed [23:0] vert_x;
      logic signed [23:0] vert_y;
      logic [15:0]        vert_index;
      logic [15:0]        tri_a;
      logic [15:0]        tri_b;
      logic [15:0]        tri_c;
      logic [31:0]        vert_color;
      logic               last;
   } rsp_word_type;

   typedef struct packed {
      logic signed [23:0] x1;
      logic signed [23:0] y1;
      logic signed [23:0] px;
      logic signed [23:0] py;
      logic signed [18:0] ux;
      logic signed [18:0] uy;
      logic [15:0]        base;
      logic [31:0]        color;
      logic [2:0]         slot;
   } geom_type;

endpackage

### hw/rtl/polyline_stroke_quad_expand.sv
// Top level of the polyline stroke quad expander.
// Sequencer with one shared multiplier and a bit-serial sqrt/divide datapath.
// Depends on psq_pkg and psq_vertex_gen.
//
// Begin, move, unused and dropped line commands emit no response words. A line
// command runs two squaring multiplies and a sum, a 32-step square root, then
// per axis one width multiply, a load and a 48-step long division, all through
// the one multiplier, with one subtract/compare unit for the root and one for the
// division, then emits six response words. A zero-length segment skips the root
// and divisions. The input is stalled until the last response word of a segment is taken.
module polyline_stroke_quad_expand (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  psq_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output psq_pkg::rsp_word_type rsp_word,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [31:0]           csr_wdata
);
   import psq_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SQX   = 4'd1;
   localparam logic [3:0] ST_SQY   = 4'd2;
   localparam logic [3:0] ST_SUM   = 4'd3;
   localparam logic [3:0] ST_SQRT  = 4'd4;
   localparam logic [3:0] ST_MUL   = 4'd5;
   localparam logic [3:0] ST_DLOAD = 4'd6;
   localparam logic [3:0] ST_DIV   = 4'd7;
   localparam logic [3:0] ST_EMIT  = 4'd8;

   logic [3:0]  state_ff, state_in;
   logic [15:0] width_ff, width_in;
   logic [31:0] rgba_ff, rgba_in;
   logic signed [23:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [15:0] base_ff, base_in;
   logic signed [23:0] x1_ff, x1_in, y1_ff, y1_in;
   logic [24:0] ax_ff, ax_in, ay_ff, ay_in;
   logic        nx_ff, nx_in, ny_ff, ny_in;
   logic [15:0] w_ff, w_in;
   logic [49:0] prod_ff, prod_in, acc_ff, acc_in;
   logic [63:0] rad_ff, rad_in;
   logic [34:0] srem_ff, srem_in;
   logic [31:0] root_ff, root_in;
   logic [47:0] num_ff, num_in;
   logic [31:0] drem_ff, drem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        axis_ff, axis_in;
   logic signed [18:0] ux_ff, ux_in, uy_ff, uy_in;
   logic [2:0]  slot_ff, slot_in;

   logic [24:0] mul_a, mul_b;
   logic [49:0] mul_p;
   logic [49:0] s_sum;
   logic [24:0] dx, dy;
   logic [34:0] sr_sh, sr_trial;
   logic        sr_ge;
   logic [32:0] dv_sh;
   logic        dv_ge;
   logic [18:0] q_pos;
   logic        req_take;
   geom_type    geom;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_EMIT);

   assign dx = 25'(req_word.pos_x) - 25'(cur_x_ff);
   assign dy = 25'(req_word.pos_y) - 25'(cur_y_ff);

   always_comb begin
      mul_a = ax_ff;
      mul_b = ax_ff;
      if (state_ff == ST_SQY) begin
         mul_a = ay_ff;
         mul_b = ay_ff;
      end else if (state_ff == ST_MUL) begin
         mul_a = axis_ff ? ay_ff : ax_ff;
         mul_b = 25'(w_ff);
      end
   end
   assign mul_p = mul_a * mul_b;

   assign s_sum    = acc_ff + prod_ff;
   assign sr_sh    = {srem_ff[32:0], rad_ff[63:62]};
   assign sr_trial = {1'b0, root_ff, 2'b01};
   assign sr_ge    = (sr_sh >= sr_trial);
   assign dv_sh    = {drem_ff, num_ff[47]};
   assign dv_ge    = (dv_sh >= {1'b0, root_ff});

   always_comb begin
      state_in = state_ff;
      width_in = width_ff;
      rgba_in  = rgba_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      base_in  = base_ff;
      x1_in    = x1_ff;
      y1_in    = y1_ff;
      ax_in    = ax_ff;
      ay_in    = ay_ff;
      nx_in    = nx_ff;
      ny_in    = ny_ff;
      w_in     = w_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      rad_in   = rad_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      num_in   = num_ff;
      drem_in  = drem_ff;
      cnt_in   = cnt_ff;
      axis_in  = axis_ff;
      ux_in    = ux_ff;
      uy_in    = uy_ff;
      slot_in  = slot_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_LINE_WIDTH:  width_in = csr_wdata[15:0];
            CSR_STROKE_RGBA: rgba_in  = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (req_word.mode)
                  MODE_BEGIN: begin
                     cur_x_in = '0;
                     cur_y_in = '0;
                     base_in  = '0;
                  end
                  MODE_MOVE: begin
                     cur_x_in = req_word.pos_x;
                     cur_y_in = req_word.pos_y;
                     base_in  = '0;
                  end
                  MODE_LINE: begin
                     x1_in    = cur_x_ff;
                     y1_in    = cur_y_ff;
                     cur_x_in = req_word.pos_x;
                     cur_y_in = req_word.pos_y;
                     nx_in    = dx[24];
                     ny_in    = dy[24];
                     ax_in    = dx[24] ? (25'd0 - dx) : dx;
                     ay_in    = dy[24] ? (25'd0 - dy) : dy;
                     w_in     = (width_ff < WIDTH_MIN) ? WIDTH_MIN : width_ff;
                     if (base_ff < BASE_LIMIT) begin
                        state_in = ST_SQX;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SQX: begin
            prod_in  = mul_p;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            acc_in   = prod_ff;
            prod_in  = mul_p;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            axis_in = 1'b0;
            slot_in = '0;
            if (s_sum == '0) begin
               ux_in    = '0;
               uy_in    = '0;
               state_in = ST_EMIT;
            end else begin
               rad_in   = {s_sum, 14'd0};
               srem_in  = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            rad_in  = {rad_ff[61:0], 2'b00};
            if (sr_ge) begin
               srem_in = sr_sh - sr_trial;
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               srem_in = sr_sh;
               root_in = {root_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = mul_p;
            state_in = ST_DLOAD;
         end
         ST_DLOAD: begin
            num_in   = {prod_ff[40:0], 7'd0} + {17'd0, root_ff[31:1]};
            drem_in  = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            drem_in = dv_ge ? 32'(dv_sh - {1'b0, root_ff}) : dv_sh[31:0];
            num_in  = {num_ff[46:0], dv_ge};
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'd47) begin
               state_in = ST_MUL;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               slot_in = slot_ff + 3'd1;
               if (slot_ff == 3'd5) begin
                  base_in  = base_ff + 16'd4;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign q_pos = {1'b0, num_in[17:0]};

   // Division finished: store the signed quotient and pick the next axis.
   logic [3:0]  state_fin;
   logic        axis_fin;
   logic signed [18:0] ux_fin, uy_fin;
   always_comb begin
      state_fin = state_in;
      axis_fin  = axis_in;
      ux_fin    = ux_in;
      uy_fin    = uy_in;
      if (state_ff == ST_DIV && cnt_ff == 6'd47) begin
         if (axis_ff == 1'b0) begin
            ux_fin    = nx_ff ? (19'sd0 - $signed(q_pos)) : $signed(q_pos);
            axis_fin  = 1'b1;
            state_fin = ST_MUL;
         end else begin
            uy_fin    = ny_ff ? (19'sd0 - $signed(q_pos)) : $signed(q_pos);
            state_fin = ST_EMIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         width_ff <= WIDTH_MIN;
         rgba_ff  <= 32'hffff_ffff;
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         base_ff  <= '0;
         slot_ff  <= '0;
         axis_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_fin;
         width_ff <= width_in;
         rgba_ff  <= rgba_in;
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         base_ff  <= base_in;
         slot_ff  <= slot_in;
         axis_ff  <= axis_fin;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff   <= x1_in;
      y1_ff   <= y1_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      nx_ff   <= nx_in;
      ny_ff   <= ny_in;
      w_ff    <= w_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      rad_ff  <= rad_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      num_ff  <= num_in;
      drem_ff <= drem_in;
      ux_ff   <= ux_fin;
      uy_ff   <= uy_fin;
   end

   assign geom.x1    = x1_ff;
   assign geom.y1    = y1_ff;
   assign geom.px    = cur_x_ff;
   assign geom.py    = cur_y_ff;
   assign geom.ux    = ux_ff;
   assign geom.uy    = uy_ff;
   assign geom.base  = base_ff;
   assign geom.color = rgba_ff;
   assign geom.slot  = slot_ff;

   psq_vertex_gen u_vertex_gen (
      .geom (geom),
      .word (rsp_word)
   );

endmodule

### hw/rtl/psq_vertex_gen.sv
// Response word builder for the polyline stroke quad expander.
// Forms one vertex or triangle word from the held segment geometry.
// Depends on psq_pkg.
module psq_vertex_gen (
   input  psq_pkg::geom_type     geom,
   output psq_pkg::rsp_word_type word
);
   import psq_pkg::*;

   logic signed [26:0] x1_e, y1_e, px_e, py_e, ux_e, uy_e;
   logic signed [26:0] sum_x, sum_y;

   function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
      logic signed [23:0] r;
      if (v > 27'sd8388607) begin
         r = 24'sh7fffff;
      end else if (v < -27'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

   assign x1_e = 27'(geom.x1);
   assign y1_e = 27'(geom.y1);
   assign px_e = 27'(geom.px);
   assign py_e = 27'(geom.py);
   assign ux_e = 27'(geom.ux);
   assign uy_e = 27'(geom.uy);

   always_comb begin
      unique case (geom.slot)
         3'd0: begin
            sum_x = x1_e - ux_e + uy_e;
            sum_y = y1_e - uy_e - ux_e;
         end
         3'd1: begin
            sum_x = px_e + ux_e + uy_e;
            sum_y = py_e + uy_e - ux_e;
         end
         3'd2: begin
            sum_x = px_e + ux_e - uy_e;
            sum_y = py_e + uy_e + ux_e;
         end
         default: begin
            sum_x = x1_e - ux_e - uy_e;
            sum_y = y1_e - uy_e + ux_e;
         end
      endcase
   end

   always_comb begin
      word = '0;
      if (geom.slot < 3'd4) begin
         word.kind       = KIND_VERTEX;
         word.vert_x     = sat24(sum_x);
         word.vert_y     = sat24(sum_y);
         word.vert_index = geom.base + 16'(geom.slot);
         word.vert_color = geom.color;
      end else if (geom.slot == 3'd4) begin
         word.kind  = KIND_TRI;
         word.tri_a = geom.base + 16'd1;
         word.tri_b = geom.base + 16'd2;
         word.tri_c = geom.base;
      end else begin
         word.kind  = KIND_TRI;
         word.tri_a = geom.base;
         word.tri_b = geom.base + 16'd2;
         word.tri_c = geom.base + 16'd3;
         word.last  = 1'b1;
      end
   end

endmodule

### dv/testbench.sv
// Testbench for polyline_stroke_quad_expand: directed and random path commands,
// with every expected stroke word predicted in the bench and checked in order.
// Depends on psq_pkg and the block's RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import psq_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 200;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_we = 1'b0;
   logic         csr_index = CSR_LINE_WIDTH;
   logic [31:0]  csr_wdata = '0;

   // stroke state mirrored in the bench
   logic signed [23:0] pen_x, pen_y;
   logic [15:0]        quad_base;
   logic [15:0]        width_q88;
   logic [31:0]        color_rgba;
   rsp_word_type       stroke_words[$];

   int error_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   polyline_stroke_quad_expand u_top (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint round_div(longint num, longint unsigned den);
      longint unsigned mag, q;
      mag = num < 0 ? longint'(-num) : longint'(num);
      q = (mag + den / 2) / den;
      return num < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [23:0] clamp24(longint v);
      if (v < -64'sd8388608) return 24'h800000;
      if (v > 64'sd8388607) return 24'h7FFFFF;
      return v[23:0];
   endfunction

   function automatic rsp_word_type corner(longint x, longint y, logic [15:0] idx);
      rsp_word_type r;
      r = '0;
      r.kind = KIND_VERTEX;
      r.vert_x = clamp24(x);
      r.vert_y = clamp24(y);
      r.vert_index = idx;
      r.vert_color = color_rgba;
      return r;
   endfunction

   function automatic rsp_word_type triangle(logic [15:0] a, logic [15:0] b,
                                             logic [15:0] c, logic fin);
      rsp_word_type r;
      r = '0;
      r.kind = KIND_TRI;
      r.tri_a = a;
      r.tri_b = b;
      r.tri_c = c;
      r.last = fin;
      return r;
   endfunction

   function automatic void predict_stroke(req_word_type w);
      longint x1, y1, px, py, dx, dy, wd, ux, uy;
      longint unsigned s, m;
      x1 = pen_x;
      y1 = pen_y;
      px = w.pos_x;
      py = w.pos_y;
      ux = 0;
      uy = 0;
      case (w.mode)
         MODE_BEGIN: begin
            pen_x = '0; pen_y = '0; quad_base = '0;
         end
         MODE_MOVE: begin
            pen_x = w.pos_x; pen_y = w.pos_y; quad_base = '0;
         end
         MODE_LINE: begin
            pen_x = w.pos_x;
            pen_y = w.pos_y;
            if (quad_base < BASE_LIMIT) begin
               dx = px - x1;
               dy = py - y1;
               wd = width_q88 < WIDTH_MIN ? WIDTH_MIN : width_q88;
               s = dx * dx + dy * dy;
               if (s != 0) begin
                  m = int_sqrt(s << 14);
                  ux = round_div(dx * wd * 128, m);
                  uy = round_div(dy * wd * 128, m);
               end
               stroke_words.push_back(corner(x1 - ux + uy, y1 - uy - ux, quad_base));
               stroke_words.push_back(corner(px + ux + uy, py + uy - ux,
                                             quad_base + 16'd1));
               stroke_words.push_back(corner(px + ux - uy, py + uy + ux,
                                             quad_base + 16'd2));
               stroke_words.push_back(corner(x1 - ux - uy, y1 - uy + ux,
                                             quad_base + 16'd3));
               stroke_words.push_back(triangle(quad_base + 16'd1, quad_base + 16'd2,
                                               quad_base, 1'b0));
               stroke_words.push_back(triangle(quad_base, quad_base + 16'd2,
                                               quad_base + 16'd3, 1'b1));
               quad_base = quad_base + 16'd4;
            end
         end
         default: ;
      endcase
   endfunction

   // result checking, receiver stalls and watchdog
   always @(posedge clock) begin
      rsp_word_type want;
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (stroke_words.size() == 0) begin
            report("unexpected word", rsp_word[31:0], 32'h0);
         end else begin
            want = stroke_words.pop_front();
            if (rsp_word.kind != want.kind)
               report("kind", 32'(rsp_word.kind), 32'(want.kind));
            if (rsp_word.vert_x != want.vert_x)
               report("vert_x", 32'(rsp_word.vert_x), 32'(want.vert_x));
            if (rsp_word.vert_y != want.vert_y)
               report("vert_y", 32'(rsp_word.vert_y), 32'(want.vert_y));
            if (rsp_word.vert_index != want.vert_index)
               report("vert_index", 32'(rsp_word.vert_index), 32'(want.vert_index));
            if (rsp_word.tri_a != want.tri_a)
               report("tri_a", 32'(rsp_word.tri_a), 32'(want.tri_a));
            if (rsp_word.tri_b != want.tri_b)
               report("tri_b", 32'(rsp_word.tri_b), 32'(want.tri_b));
            if (rsp_word.tri_c != want.tri_c)
               report("tri_c", 32'(rsp_word.tri_c), 32'(want.tri_c));
            if (rsp_word.vert_color != want.vert_color)
               report("vert_color", rsp_word.vert_color, want.vert_color);
            if (rsp_word.last != want.last)
               report("last", 32'(rsp_word.last), 32'(want.last));
         end
      end
      if (reset || (rsp_valid && !rsp_stall) || (req_valid && !req_stall) || csr_we)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_cmd(logic [1:0] mode, logic [23:0] x, logic [23:0] y);
      req_word_type w;
      int gap;
      w.mode = mode;
      w.pos_x = x;
      w.pos_y = y;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(8, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_stroke(w);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (stroke_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [31:0] data);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_LINE_WIDTH) width_q88 = data[15:0];
      else color_rgba = data;
   endtask

   task automatic test_directed();
      send_cmd(MODE_BEGIN, 24'h0, 24'h0);
      send_cmd(MODE_LINE, 24'h000A00, 24'h0);
      send_cmd(MODE_LINE, 24'h000A00, 24'h0);
      send_cmd(MODE_LINE, 24'h000A00, 24'h001400);
      send_cmd(MODE_UNUSED, 24'h123456, 24'hABCDEF);
      send_cmd(MODE_LINE, 24'hFFF600, 24'hFFEC00);
      send_cmd(MODE_MOVE, 24'h800000, 24'h800000);
      send_cmd(MODE_LINE, 24'h7FFFFF, 24'h7FFFFF);
      send_cmd(MODE_LINE, 24'h800000, 24'h7FFFFF);
      send_cmd(MODE_LINE, 24'h7FFFFF, 24'h800000);
      send_cmd(MODE_LINE, 24'h7FFFFF, 24'h7FFFFE);
      send_cmd(MODE_BEGIN, 24'hFFFFFF, 24'hFFFFFF);
      send_cmd(MODE_LINE, 24'h000001, 24'hFFFFFF);
      write_reg(CSR_LINE_WIDTH, 32'h0000FFFF);
      write_reg(CSR_STROKE_RGBA, 32'h00000000);
      send_cmd(MODE_MOVE, 24'h7FFF00, 24'h000100);
      send_cmd(MODE_LINE, 24'h7FFFFF, 24'h000200);
      send_cmd(MODE_LINE, 24'h000000, 24'h000000);
      write_reg(CSR_LINE_WIDTH, 32'h00000000);
      write_reg(CSR_STROKE_RGBA, 32'h5A5AA5A5);
      send_cmd(MODE_LINE, 24'h000300, 24'h000400);
      write_reg(CSR_LINE_WIDTH, 32'h00000100);
      write_reg(CSR_STROKE_RGBA, 32'hFFFFFFFF);
      send_cmd(MODE_LINE, 24'h000000, 24'h000000);
      drain();
   endtask

   task automatic test_random(int count);
      int pick;
      logic [23:0] x, y;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            x = pen_x + 24'($signed($urandom_range(8192)) - 4096);
            y = pen_y + 24'($signed($urandom_range(8192)) - 4096);
         end else begin
            x = 24'($urandom);
            y = 24'($urandom);
         end
         if (pick < 80) send_cmd(MODE_LINE, x, y);
         else if (pick < 90) send_cmd(MODE_MOVE, x, y);
         else if (pick < 95) send_cmd(MODE_BEGIN, x, y);
         else send_cmd(MODE_UNUSED, x, y);
      end
      drain();
   endtask

   task automatic test_backpressure();
      hold_left = 800;
      for (int i = 0; i < 6; i++)
         send_cmd(MODE_LINE, 24'($urandom), 24'($urandom));
      drain();
   endtask

   initial begin
      pen_x = '0;
      pen_y = '0;
      quad_base = '0;
      width_q88 = 16'd256;
      color_rgba = 32'hFFFFFFFF;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_idle_pct = 30;
      recv_idle_pct = 72;
      write_reg(CSR_LINE_WIDTH, $urandom_range(65535, 256));
      test_random(76);
      test_backpressure();
      send_idle_pct = 72;
      recv_idle_pct = 30;
      write_reg(CSR_STROKE_RGBA, $urandom);
      test_random(76);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(CSR_LINE_WIDTH, 32'h00000100);
      test_random(76);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule

### files.f
hw/rtl/psq_pkg.sv
hw/rtl/psq_vertex_gen.sv
hw/rtl/polyline_stroke_quad_expand.sv
dv/testbench.sv
